[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is masked while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Same, for a property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/obrb_pkg.sv]
`timescale 1ns / 1ps

package obrb_pkg;

    localparam int CAP_W     = 9;
    localparam int DATA_W    = 8;
    localparam int CAP_RESET = 256;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_UNGET = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DATA_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              data_valid;
        logic              oldest_dropped;
        logic              unget_refused;
        logic [CAP_W-1:0]  fill_count;
        logic [CAP_W-1:0]  room_left;
    } t_out_item;

endpackage

[rtl/overwriting_byte_ring_buffer_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_ready     i_in_item  (t_in_item)
// out       source     o_out_valid / i_out_ready   o_out_item (t_out_item)
// cfg       sink       i_cfg_we                    i_cfg_data (capacity in use)
//
// One item per clock while the output is not stalled; each item passes through
// the memory read stage, then the output register.
// Head, count and the memory write are settled at accept; a pop's byte comes
// from the registered memory read, in the cycle after accept.
// Synchronous active-low reset clears pointers and valids; the byte memory
// is not cleared (unwritten entries are never read back).
// A stalled output holds the read stage, which then holds the input.

module overwriting_byte_ring_buffer_core
    import obrb_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW + 1 > CAP_W + 1) ? AW + 1 : CAP_W + 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [CAP_W-1:0]  r_cap;
    logic [AW-1:0]     r_head;
    logic [CAP_W-1:0]  r_count;

    logic              r_s1_valid;
    t_out_item         r_s1;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CAP_W-1:0]  w_cap;
    logic [CW-1:0]     w_cap_x, w_head_x, w_cnt_x, w_sum;
    logic [AW-1:0]     w_tail, w_head_inc, w_head_dec;
    logic              w_full, w_empty;
    logic              w_accept, w_out_free;

    logic [AW-1:0]     n_head;
    logic [CAP_W-1:0]  n_count;
    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr;
    t_out_item         w_s1;
    t_out_item         w_out;

    // Effective capacity: zero acts as one, clamp to the storage depth.
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (CW'(r_cap) > CW'(DEPTH)) begin
            w_cap = CAP_W'(DEPTH);
        end else begin
            w_cap = r_cap;
        end
    end

    assign w_cap_x  = CW'(w_cap);
    assign w_head_x = CW'(r_head);
    assign w_cnt_x  = CW'(r_count);
    assign w_sum    = w_head_x + w_cnt_x;

    // head < cap and count <= cap, so one conditional subtract wraps
    assign w_tail     = AW'((w_sum >= w_cap_x) ? (w_sum - w_cap_x) : w_sum);
    assign w_head_inc = AW'((w_head_x + CW'(1) == w_cap_x) ? '0 : (w_head_x + CW'(1)));
    assign w_head_dec = AW'((r_head == '0) ? (w_cap_x - CW'(1)) : (w_head_x - CW'(1)));

    assign w_full  = (r_count == w_cap);
    assign w_empty = (r_count == '0);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_tail;
        w_s1    = '0;
        case (t_mode'(i_in_item.mode))
            MODE_PUSH: begin
                w_we = 1'b1;
                if (w_full) begin
                    n_head = w_head_inc;
                    w_s1.oldest_dropped = 1'b1;
                end else begin
                    n_count = r_count + CAP_W'(1);
                end
            end
            MODE_POP: begin
                if (!w_empty) begin
                    w_re = 1'b1;
                    w_s1.data_valid = 1'b1;
                    n_head  = w_head_inc;
                    n_count = r_count - CAP_W'(1);
                end
            end
            MODE_UNGET: begin
                if (w_full) begin
                    w_s1.unget_refused = 1'b1;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_head_dec;
                    n_head  = w_head_dec;
                    n_count = r_count + CAP_W'(1);
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        w_s1.fill_count = n_count;
        w_s1.room_left  = w_cap - n_count;
    end

    // popped byte joins the rest of the result on its way out
    always_comb begin
        w_out          = r_s1;
        w_out.data_out = r_s1.data_valid ? r_rdata : '0;
    end

    // Byte memory: one write or one read per item, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_mem[w_waddr] <= i_in_item.data_in;
        end
        if (w_accept && w_re) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_W'(CAP_RESET);
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= i_cfg_data;
            r_head  <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_s1;
        end
        if (r_s1_valid && w_out_free) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/obrb_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module obrb_checker
    import obrb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_item
);

    // a result held back by the sink stays put
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)),
        "output item changed while stalled")

    `ASSERT_CLK(a_flags_excl, i_clk, i_rst_n,
        o_out_valid |-> ($countones({o_out_item.data_valid, o_out_item.oldest_dropped,
                                     o_out_item.unget_refused}) <= 1),
        "more than one status flag set")

    `ASSERT_CLK(a_data_zero, i_clk, i_rst_n,
        (o_out_valid && !o_out_item.data_valid) |-> (o_out_item.data_out == '0),
        "data_out nonzero without a popped byte")

    // drop or refusal only happens on a full ring
    `ASSERT_CLK(a_full_flags, i_clk, i_rst_n,
        (o_out_valid && (o_out_item.oldest_dropped || o_out_item.unget_refused))
            |-> (o_out_item.room_left == '0),
        "full-ring flag with room left")

endmodule

bind overwriting_byte_ring_buffer_core obrb_checker u_obrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
